// ----- hdl/battery_fault_supervisor_top_macros.svh -----
// assertion macros for the battery fault supervisor
`ifndef BATTERY_FAULT_SUPERVISOR_TOP_MACROS_SVH
`define BATTERY_FAULT_SUPERVISOR_TOP_MACROS_SVH

// condition now implies consequence now
`define BFS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// condition now implies consequence at the next clock
`define BFS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/bfs_pkg.sv -----
// types and constants of the battery fault supervisor
`default_nettype none
package bfs_pkg;

  typedef struct packed {
    logic        mode;
    logic [31:0] time_ms;
    logic        cell_link_error;
    logic        aux_link_error;
    logic        limit_link_error;
    logic [1:0]  voltage_fault_code;
    logic [15:0] current_code;
    logic [15:0] temperature_code;
  } in_item_t;

  typedef struct packed {
    logic [7:0] status_flags;
    logic       failed;
    logic [1:0] fail_cause;
    logic [1:0] relay_command;
  } out_item_t;

  // item kinds
  localparam logic MODE_REPORT  = 1'b0;
  localparam logic MODE_TIMEOUT = 1'b1;

  // relay commands
  localparam logic [1:0] RELAY_NONE    = 2'd0;
  localparam logic [1:0] RELAY_OPEN    = 2'd1;
  localparam logic [1:0] RELAY_RELEASE = 2'd2;

  // failure causes
  localparam logic [1:0] CAUSE_NONE    = 2'd0;
  localparam logic [1:0] CAUSE_LINK    = 2'd1;
  localparam logic [1:0] CAUSE_TIMEOUT = 2'd2;

  // register indexes
  localparam logic [2:0] REG_HOT_LIMIT    = 3'd0;
  localparam logic [2:0] REG_COLD_LIMIT   = 3'd1;
  localparam logic [2:0] REG_ZERO_CODE    = 3'd2;
  localparam logic [2:0] REG_CHARGE_LIM   = 3'd3;
  localparam logic [2:0] REG_DISCHG_LIM   = 3'd4;
  localparam logic [2:0] REG_VOLT_HOLD    = 3'd5;
  localparam logic [2:0] REG_TEMP_HOLD    = 3'd6;
  localparam logic [2:0] REG_CURRENT_HOLD = 3'd7;

  // register reset values
  localparam logic [15:0]        HOT_LIMIT_RST    = 16'd6500;
  localparam logic [15:0]        COLD_LIMIT_RST   = 16'd23000;
  localparam logic [15:0]        ZERO_CODE_RST    = 16'd30090;
  localparam logic signed [16:0] CHARGE_LIM_RST   = 17'sd5000;
  localparam logic signed [16:0] DISCHG_LIM_RST   = -17'sd28000;
  localparam logic [15:0]        VOLT_HOLD_RST    = 16'd500;
  localparam logic [15:0]        TEMP_HOLD_RST    = 16'd1000;
  localparam logic [15:0]        CURRENT_HOLD_RST = 16'd500;

  // fixed limits
  localparam logic [31:0] COOLDOWN_MS        = 32'd100;
  localparam logic [2:0]  LINK_FAIL_LIMIT    = 3'd5;
  localparam logic [2:0]  TIMEOUT_FAIL_LIMIT = 3'd3;
  localparam logic [2:0]  COUNT_MAX          = 3'd7;

endpackage
`default_nettype wire

// ----- hdl/battery_fault_supervisor_top.sv -----
// battery fault supervisor top level
//
// battery fault supervisor: each item is a measurement report or a conversion
// timeout, stamped with a free-running millisecond time (elapsed time is taken
// modulo 2^32). voltage, temperature and overcurrent faults each run a
// persistence timer; a fault that outlasts its hold time asks for the relay to
// open and is latched in the high nibble of status_flags. a voltage fault only
// clears after 100 ms of cooldown. repeated link checksum errors or repeated
// conversion timeouts put the block into a sticky failure state, after which
// every item returns relay open and nothing else changes. exactly one result
// item leaves for every input item: the whole update is a single pass of logic
// from the input port into the state and the result register, so one item is
// taken every cycle while in_stall is low. the result register frees as its
// item is taken, so in_stall only rises while a result waits under out_stall.
// the user must write limits and hold times over the APB-style port while the
// block is idle (unchecked by the block); there is no clearing pass after reset.
`default_nettype none
module battery_fault_supervisor_top
  import bfs_pkg::*;
#(
  parameter int SLOT_COUNT       = 16,
  parameter int CHECKED_SLOTS    = 10,
  parameter int CELL_READ_PERIOD = 100
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  // input channel
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_data,
  // result channel
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_data,
  // configuration port
  input  wire logic      psel,
  input  wire logic      penable,
  input  wire logic      pwrite,
  input  wire logic [4:0] paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);

  localparam int SLOT_W  = $clog2(SLOT_COUNT);
  localparam int NCHK    = (CHECKED_SLOTS < SLOT_COUNT) ? CHECKED_SLOTS : SLOT_COUNT;
  localparam int CRC_W   = $clog2(CELL_READ_PERIOD + 1);

  // configuration registers
  logic [15:0]        hot_lim_r, cold_lim_r, zero_code_r;
  logic signed [16:0] chg_lim_r, dis_lim_r;
  logic [15:0]        volt_hold_r, temp_hold_r, cur_hold_r;

  // supervisor state
  logic              fail_flag_r, fail_flag_nxt;
  logic [1:0]        fail_code_r, fail_code_nxt;
  logic [2:0]        tmo_cnt_r, tmo_cnt_nxt;
  logic [CRC_W-1:0]  cell_cnt_r, cell_cnt_nxt;
  logic [2:0]        link_cnt_r [3];
  logic [2:0]        link_cnt_nxt [3];
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [SLOT_COUNT-1:0] slot_oor_r, slot_oor_nxt;
  logic              volt_act_r, volt_act_nxt;
  logic              cool_act_r, cool_act_nxt;
  logic              temp_act_r, temp_act_nxt;
  logic              cur_act_r, cur_act_nxt;
  logic [31:0]       t_volt_r, t_volt_nxt;
  logic [31:0]       t_cool_r, t_cool_nxt;
  logic [31:0]       t_temp_r, t_temp_nxt;
  logic [31:0]       t_cur_r, t_cur_nxt;
  logic [7:0]        status_r, status_nxt;

  // result register
  logic              out_valid_r;
  out_item_t         out_data_r, out_data_nxt;

  logic              in_acc;
  logic              cfg_wr;
  logic [2:0]        cfg_idx;

  // per-item working values
  logic               open_req;
  logic [1:0]         relay;
  logic signed [16:0] cur_val;
  logic               temp_any;
  logic               cell_err_eff;
  logic [31:0]        el_volt, el_cool, el_temp, el_cur;

  // saturating link error counter step
  function automatic logic [2:0] bump(input logic [2:0] cnt, input logic err);
    logic [2:0] res;
    res = 3'd0;
    if (err) begin
      res = (cnt < COUNT_MAX) ? cnt + 3'd1 : cnt;
    end
    return res;
  endfunction

  // handshakes: the result register frees as its item leaves
  assign in_stall  = out_valid_r & out_stall;
  assign in_acc    = in_valid & ~in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = paddr[4:2];

  // register readback, signed limits sign extended
  always_comb begin
    unique case (cfg_idx)
      REG_HOT_LIMIT:    prdata = {16'd0, hot_lim_r};
      REG_COLD_LIMIT:   prdata = {16'd0, cold_lim_r};
      REG_ZERO_CODE:    prdata = {16'd0, zero_code_r};
      REG_CHARGE_LIM:   prdata = {{15{chg_lim_r[16]}}, chg_lim_r};
      REG_DISCHG_LIM:   prdata = {{15{dis_lim_r[16]}}, dis_lim_r};
      REG_VOLT_HOLD:    prdata = {16'd0, volt_hold_r};
      REG_TEMP_HOLD:    prdata = {16'd0, temp_hold_r};
      REG_CURRENT_HOLD: prdata = {16'd0, cur_hold_r};
    endcase
  end

  // elapsed times since each timer start, modulo 2^32
  assign el_volt = in_data.time_ms - t_volt_r;
  assign el_cool = in_data.time_ms - t_cool_r;
  assign el_temp = in_data.time_ms - t_temp_r;
  assign el_cur  = in_data.time_ms - t_cur_r;

  // signed current relative to the sensor zero point
  assign cur_val = $signed({1'b0, in_data.current_code}) - $signed({1'b0, zero_code_r});

  // whole update for one item
  always_comb begin
    fail_flag_nxt = fail_flag_r;
    fail_code_nxt = fail_code_r;
    tmo_cnt_nxt   = tmo_cnt_r;
    cell_cnt_nxt  = cell_cnt_r;
    for (int k = 0; k < 3; k++) begin
      link_cnt_nxt[k] = link_cnt_r[k];
    end
    slot_nxt     = slot_r;
    slot_oor_nxt = slot_oor_r;
    volt_act_nxt = volt_act_r;
    cool_act_nxt = cool_act_r;
    temp_act_nxt = temp_act_r;
    cur_act_nxt  = cur_act_r;
    t_volt_nxt   = t_volt_r;
    t_cool_nxt   = t_cool_r;
    t_temp_nxt   = t_temp_r;
    t_cur_nxt    = t_cur_r;
    status_nxt   = status_r;
    open_req     = 1'b0;
    relay        = RELAY_NONE;
    cell_err_eff = 1'b0;
    temp_any     = 1'b0;

    if (!fail_flag_r) begin
      if (in_data.mode == MODE_TIMEOUT) begin
        // conversion timeout, status stays as it was
        tmo_cnt_nxt = (tmo_cnt_r < COUNT_MAX) ? tmo_cnt_r + 3'd1 : tmo_cnt_r;
        if (tmo_cnt_nxt > TIMEOUT_FAIL_LIMIT) begin
          fail_flag_nxt = 1'b1;
          fail_code_nxt = CAUSE_TIMEOUT;
        end
      end else begin
        tmo_cnt_nxt = 3'd0;
        // cell readback is only checked on one report in every CELL_READ_PERIOD + 1
        if (cell_cnt_r >= CRC_W'(CELL_READ_PERIOD)) begin
          cell_cnt_nxt = '0;
        end else begin
          cell_cnt_nxt = cell_cnt_r + CRC_W'(1);
        end
        cell_err_eff    = in_data.cell_link_error & (cell_cnt_nxt == '0);
        link_cnt_nxt[0] = bump(link_cnt_r[0], cell_err_eff);
        link_cnt_nxt[1] = bump(link_cnt_r[1], in_data.aux_link_error);
        link_cnt_nxt[2] = bump(link_cnt_r[2], in_data.limit_link_error);

        if (!in_data.aux_link_error) begin
          slot_oor_nxt[slot_r] = (in_data.temperature_code < hot_lim_r) ||
                                 (in_data.temperature_code > cold_lim_r);
        end

        // voltage routine with cooldown
        if (!in_data.limit_link_error) begin
          status_nxt[1:0] = in_data.voltage_fault_code;
          if (in_data.voltage_fault_code != 2'd0) begin
            cool_act_nxt = 1'b0;
            if (!volt_act_r) begin
              volt_act_nxt = 1'b1;
              t_volt_nxt   = in_data.time_ms;
            end else if (el_volt > {16'd0, volt_hold_r}) begin
              open_req        = 1'b1;
              status_nxt[5:4] = status_r[5:4] | in_data.voltage_fault_code;
            end
          end else if (volt_act_r) begin
            if (!cool_act_r) begin
              cool_act_nxt = 1'b1;
              t_cool_nxt   = in_data.time_ms;
            end else if (el_cool > COOLDOWN_MS) begin
              volt_act_nxt = 1'b0;
              cool_act_nxt = 1'b0;
            end
          end
        end

        // temperature and current routines
        if (!in_data.aux_link_error) begin
          temp_any = |slot_oor_nxt[NCHK-1:0];
          if (temp_any) begin
            status_nxt[2] = 1'b1;
            if (!temp_act_r) begin
              temp_act_nxt = 1'b1;
              t_temp_nxt   = in_data.time_ms;
            end else if (el_temp > {16'd0, temp_hold_r}) begin
              open_req      = 1'b1;
              status_nxt[6] = 1'b1;
            end
          end else begin
            temp_act_nxt  = 1'b0;
            status_nxt[2] = 1'b0;
          end

          if ((cur_val > chg_lim_r) || (cur_val < dis_lim_r)) begin
            status_nxt[3] = 1'b1;
            if (!cur_act_r) begin
              cur_act_nxt = 1'b1;
              t_cur_nxt   = in_data.time_ms;
            end else if (el_cur > {16'd0, cur_hold_r}) begin
              open_req      = 1'b1;
              status_nxt[7] = 1'b1;
            end
          end else begin
            cur_act_nxt   = 1'b0;
            status_nxt[3] = 1'b0;
          end
        end

        // open takes priority over release
        priority if (open_req) begin
          relay = RELAY_OPEN;
        end else if (status_nxt[3:0] == 4'd0) begin
          relay = RELAY_RELEASE;
        end else begin
          relay = RELAY_NONE;
        end

        slot_nxt = (slot_r == SLOT_W'(SLOT_COUNT - 1)) ? '0 : slot_r + SLOT_W'(1);

        if ((link_cnt_nxt[0] > LINK_FAIL_LIMIT) || (link_cnt_nxt[1] > LINK_FAIL_LIMIT) ||
            (link_cnt_nxt[2] > LINK_FAIL_LIMIT)) begin
          fail_flag_nxt = 1'b1;
          fail_code_nxt = CAUSE_LINK;
        end
      end
    end

    // failure forces the relay open from the entering item onward
    if (fail_flag_nxt) begin
      relay = RELAY_OPEN;
    end

    out_data_nxt.status_flags  = status_nxt;
    out_data_nxt.failed        = fail_flag_nxt;
    out_data_nxt.fail_cause    = fail_code_nxt;
    out_data_nxt.relay_command = relay;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hot_lim_r   <= HOT_LIMIT_RST;
      cold_lim_r  <= COLD_LIMIT_RST;
      zero_code_r <= ZERO_CODE_RST;
      chg_lim_r   <= CHARGE_LIM_RST;
      dis_lim_r   <= DISCHG_LIM_RST;
      volt_hold_r <= VOLT_HOLD_RST;
      temp_hold_r <= TEMP_HOLD_RST;
      cur_hold_r  <= CURRENT_HOLD_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_HOT_LIMIT:    hot_lim_r   <= pwdata[15:0];
        REG_COLD_LIMIT:   cold_lim_r  <= pwdata[15:0];
        REG_ZERO_CODE:    zero_code_r <= pwdata[15:0];
        REG_CHARGE_LIM:   chg_lim_r   <= $signed(pwdata[16:0]);
        REG_DISCHG_LIM:   dis_lim_r   <= $signed(pwdata[16:0]);
        REG_VOLT_HOLD:    volt_hold_r <= pwdata[15:0];
        REG_TEMP_HOLD:    temp_hold_r <= pwdata[15:0];
        REG_CURRENT_HOLD: cur_hold_r  <= pwdata[15:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fail_flag_r <= 1'b0;
      fail_code_r <= CAUSE_NONE;
      tmo_cnt_r   <= 3'd0;
      cell_cnt_r  <= '0;
      for (int k = 0; k < 3; k++) begin
        link_cnt_r[k] <= 3'd0;
      end
      slot_r      <= '0;
      slot_oor_r  <= '0;
      volt_act_r  <= 1'b0;
      cool_act_r  <= 1'b0;
      temp_act_r  <= 1'b0;
      cur_act_r   <= 1'b0;
      t_volt_r    <= 32'd0;
      t_cool_r    <= 32'd0;
      t_temp_r    <= 32'd0;
      t_cur_r     <= 32'd0;
      status_r    <= 8'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        fail_flag_r <= fail_flag_nxt;
        fail_code_r <= fail_code_nxt;
        tmo_cnt_r   <= tmo_cnt_nxt;
        cell_cnt_r  <= cell_cnt_nxt;
        for (int k = 0; k < 3; k++) begin
          link_cnt_r[k] <= link_cnt_nxt[k];
        end
        slot_r      <= slot_nxt;
        slot_oor_r  <= slot_oor_nxt;
        volt_act_r  <= volt_act_nxt;
        cool_act_r  <= cool_act_nxt;
        temp_act_r  <= temp_act_nxt;
        cur_act_r   <= cur_act_nxt;
        t_volt_r    <= t_volt_nxt;
        t_cool_r    <= t_cool_nxt;
        t_temp_r    <= t_temp_nxt;
        t_cur_r     <= t_cur_nxt;
        status_r    <= status_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_data_r <= out_data_nxt;
    end
  end

  `include "battery_fault_supervisor_top_macros.svh"

  // failure is sticky
  `BFS_ASSERT_NEXT(a_fail_sticky, fail_flag_r, fail_flag_r, "failure state was left")
  // nothing moves once failed
  `BFS_ASSERT_NEXT(a_fail_frozen, fail_flag_r, $stable(status_r), "status changed while failed")
  // a cause is recorded exactly when failed
  `BFS_ASSERT_NOW(a_fail_cause, 1'b1, fail_flag_r == (fail_code_r != CAUSE_NONE), "cause mismatch")
  // a failed result always asks for the relay to open
  `BFS_ASSERT_NOW(a_fail_relay, out_valid_r && out_data_r.failed,
                  out_data_r.relay_command == RELAY_OPEN, "failed item without relay open")

endmodule
`default_nettype wire

// ----- dv/bfs_supervision_checker.sv -----
// scoreboard that predicts and checks every result item of the fault supervisor
module bfs_supervision_checker
  import bfs_pkg::*;
#(
  parameter int SLOT_COUNT       = 16,
  parameter int CHECKED_SLOTS    = 10,
  parameter int CELL_READ_PERIOD = 100
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  in_item_t    in_data,
  input  logic        out_valid,
  input  logic        out_stall,
  input  out_item_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output int          mismatches,
  output int          due_count
);
  timeunit 1ns;
  timeprecision 1ps;

  // register copies
  logic [15:0] hot_lim, cold_lim, zero_code;
  int          chg_lim, dis_lim;
  logic [15:0] volt_hold, temp_hold, curr_hold;

  // supervisor state
  logic                  failed_q;
  logic [1:0]            cause_q;
  logic [2:0]            tmo_cnt;
  logic [6:0]            read_cnt;
  logic [2:0]            link_cnt [3];
  int                    slot_ptr;
  logic [SLOT_COUNT-1:0] slot_bad;
  int                    amps;
  logic                  volt_on, cool_on, temp_on, curr_on;
  logic [31:0]           volt_t0, cool_t0, temp_t0, curr_t0;
  logic [7:0]            status;

  out_item_t due_results [$];

  function automatic logic [2:0] bump_link(logic [2:0] n, logic err);
    if (!err) return 3'd0;
    return (n < COUNT_MAX) ? n + 3'd1 : n;
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
    end
  endfunction

  function automatic out_item_t supervise(in_item_t it);
    out_item_t   r;
    logic [1:0]  relay;
    logic        open_relay;
    logic        any_slot;
    logic [31:0] gone;
    relay      = RELAY_NONE;
    open_relay = 1'b0;
    any_slot   = 1'b0;
    if (!failed_q) begin
      if (it.mode == MODE_TIMEOUT) begin
        if (tmo_cnt < COUNT_MAX) tmo_cnt++;
        if (tmo_cnt > TIMEOUT_FAIL_LIMIT) begin
          failed_q = 1'b1;
          cause_q  = CAUSE_TIMEOUT;
        end
      end else begin
        tmo_cnt = '0;
        if (read_cnt >= CELL_READ_PERIOD) read_cnt = '0;
        else read_cnt++;
        link_cnt[0] = bump_link(link_cnt[0], it.cell_link_error && read_cnt == 0);
        link_cnt[1] = bump_link(link_cnt[1], it.aux_link_error);
        link_cnt[2] = bump_link(link_cnt[2], it.limit_link_error);

        if (!it.aux_link_error) begin
          amps = int'(it.current_code) - int'(zero_code);
          slot_bad[slot_ptr] = (it.temperature_code < hot_lim) ||
                               (it.temperature_code > cold_lim);
        end

        // voltage with cooldown
        if (!it.limit_link_error) begin
          status = {status[7:2], it.voltage_fault_code};
          if (it.voltage_fault_code != 2'd0) begin
            cool_on = 1'b0;
            gone    = it.time_ms - volt_t0;
            if (!volt_on) begin
              volt_on = 1'b1;
              volt_t0 = it.time_ms;
            end else if (gone > volt_hold) begin
              open_relay  = 1'b1;
              status[5:4] = status[5:4] | it.voltage_fault_code;
            end
          end else if (volt_on) begin
            gone = it.time_ms - cool_t0;
            if (!cool_on) begin
              cool_on = 1'b1;
              cool_t0 = it.time_ms;
            end else if (gone > COOLDOWN_MS) begin
              volt_on = 1'b0;
              cool_on = 1'b0;
            end
          end
        end

        if (!it.aux_link_error) begin
          for (int j = 0; j < CHECKED_SLOTS && j < SLOT_COUNT; j++)
            if (slot_bad[j]) any_slot = 1'b1;
          if (any_slot) begin
            status[2] = 1'b1;
            gone      = it.time_ms - temp_t0;
            if (!temp_on) begin
              temp_on = 1'b1;
              temp_t0 = it.time_ms;
            end else if (gone > temp_hold) begin
              open_relay = 1'b1;
              status[6]  = 1'b1;
            end
          end else begin
            temp_on   = 1'b0;
            status[2] = 1'b0;
          end

          if (amps > chg_lim || amps < dis_lim) begin
            status[3] = 1'b1;
            gone      = it.time_ms - curr_t0;
            if (!curr_on) begin
              curr_on = 1'b1;
              curr_t0 = it.time_ms;
            end else if (gone > curr_hold) begin
              open_relay = 1'b1;
              status[7]  = 1'b1;
            end
          end else begin
            curr_on   = 1'b0;
            status[3] = 1'b0;
          end
        end

        if (open_relay) relay = RELAY_OPEN;
        else if (status[3:0] == 4'd0) relay = RELAY_RELEASE;

        slot_ptr = (slot_ptr + 1) % SLOT_COUNT;

        if (link_cnt[0] > LINK_FAIL_LIMIT || link_cnt[1] > LINK_FAIL_LIMIT ||
            link_cnt[2] > LINK_FAIL_LIMIT) begin
          failed_q = 1'b1;
          cause_q  = CAUSE_LINK;
        end
      end
    end
    if (failed_q) relay = RELAY_OPEN;
    r.status_flags  = status;
    r.failed        = failed_q;
    r.fail_cause    = cause_q;
    r.relay_command = relay;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    out_item_t want;
    if (!rst_n) begin
      hot_lim    = HOT_LIMIT_RST;
      cold_lim   = COLD_LIMIT_RST;
      zero_code  = ZERO_CODE_RST;
      chg_lim    = CHARGE_LIM_RST;
      dis_lim    = DISCHG_LIM_RST;
      volt_hold  = VOLT_HOLD_RST;
      temp_hold  = TEMP_HOLD_RST;
      curr_hold  = CURRENT_HOLD_RST;
      failed_q   = 1'b0;
      cause_q    = CAUSE_NONE;
      tmo_cnt    = '0;
      read_cnt   = '0;
      link_cnt   = '{default: '0};
      slot_ptr   = 0;
      slot_bad   = '0;
      amps       = 0;
      volt_on    = 1'b0;
      cool_on    = 1'b0;
      temp_on    = 1'b0;
      curr_on    = 1'b0;
      volt_t0    = '0;
      cool_t0    = '0;
      temp_t0    = '0;
      curr_t0    = '0;
      status     = '0;
      mismatches = 0;
      due_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          mismatches++;
          $display("%0t: result %h arrived with nothing expected", $time, out_data);
        end else begin
          want = due_results.pop_front();
          check_field("status_flags", want.status_flags, out_data.status_flags);
          check_field("failed", want.failed, out_data.failed);
          check_field("fail_cause", want.fail_cause, out_data.fail_cause);
          check_field("relay_command", want.relay_command, out_data.relay_command);
        end
      end
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          REG_HOT_LIMIT:    hot_lim   = pwdata[15:0];
          REG_COLD_LIMIT:   cold_lim  = pwdata[15:0];
          REG_ZERO_CODE:    zero_code = pwdata[15:0];
          REG_CHARGE_LIM:   chg_lim   = $signed(pwdata[16:0]);
          REG_DISCHG_LIM:   dis_lim   = $signed(pwdata[16:0]);
          REG_VOLT_HOLD:    volt_hold = pwdata[15:0];
          REG_TEMP_HOLD:    temp_hold = pwdata[15:0];
          REG_CURRENT_HOLD: curr_hold = pwdata[15:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) due_results.push_back(supervise(in_data));
    end
    due_count = due_results.size();
  end

endmodule

// ----- dv/battery_fault_supervisor_top_tb.sv -----
// stimulus, clock, reset and verdict for the battery fault supervisor
module battery_fault_supervisor_top_tb
  import bfs_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  // register settings applied phase by phase
  typedef enum {SET_TYPICAL, SET_MIN, SET_MAX, SET_RANDOM, SET_RESET} setting_t;
  // how the run finally drives the block into its sticky failure
  typedef enum {ROUTE_TIMEOUTS, ROUTE_AUX_ERRORS, ROUTE_LIMIT_ERRORS} fail_route_t;

  localparam setting_t PLAN [6] = '{SET_TYPICAL, SET_MIN, SET_TYPICAL,
                                     SET_MAX, SET_RANDOM, SET_RESET};
  localparam int ITEMS_PER_PHASE = 320;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_data;
  logic        psel, penable, pwrite, pready;
  logic [4:0]  paddr;
  logic [31:0] pwdata, prdata;

  int mismatches;
  int due_count;

  // idling percentages of sender and receiver
  int idle_pct;
  int stall_pct;

  // stimulus shaping: timestamp, fault episodes and error runs
  logic [31:0] now_ms;
  logic        volt_ep, temp_ep, curr_ep;
  int          tmo_run, aux_run, lim_run;

  // copies of the limits in force, used to aim codes near the thresholds
  int hot_lim, cold_lim, zero_code, chg_lim, dis_lim;

  battery_fault_supervisor_top u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  bfs_supervision_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .pready    (pready),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .mismatches(mismatches),
    .due_count (due_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver back-pressure, redrawn every cycle
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #4_000_000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic logic [15:0] clamp16(int v);
    if (v < 0) return 16'd0;
    if (v > 65535) return 16'hFFFF;
    return v[15:0];
  endfunction

  // present one item at a falling edge and hold it until the block takes it
  task automatic send_item(input in_item_t it);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    // runs that would tip the block into failure too early
    if (it.mode == MODE_TIMEOUT) begin
      tmo_run++;
    end else begin
      tmo_run = 0;
      aux_run = it.aux_link_error ? aux_run + 1 : 0;
      lim_run = it.limit_link_error ? lim_run + 1 : 0;
    end
  endtask

  task automatic send_report(input logic [31:0] t, input logic cell_err, input logic aux,
                             input logic lim, input logic [1:0] volts,
                             input logic [15:0] amps, input logic [15:0] therm);
    in_item_t it;
    it.mode               = MODE_REPORT;
    it.time_ms            = t;
    it.cell_link_error    = cell_err;
    it.aux_link_error     = aux;
    it.limit_link_error   = lim;
    it.voltage_fault_code = volts;
    it.current_code       = amps;
    it.temperature_code   = therm;
    send_item(it);
  endtask

  task automatic send_timeout(input logic [31:0] t);
    in_item_t it;
    it      = '0;
    it.mode = MODE_TIMEOUT;
    it.time_ms = t;
    send_item(it);
  endtask

  // random item: mostly healthy reports with fault episodes long enough to
  // run the persistence timers out, plus timeouts and checksum errors kept
  // short of the failure thresholds
  task automatic make_item(output in_item_t it);
    int step_pick;
    int pick;
    it = '0;
    if ($urandom_range(99) < 6) volt_ep = !volt_ep;
    if ($urandom_range(99) < 5) temp_ep = !temp_ep;
    if ($urandom_range(99) < 6) curr_ep = !curr_ep;

    step_pick = $urandom_range(99);
    if (step_pick >= 5) now_ms += $urandom_range(60, 1);
    else if (step_pick >= 2) now_ms += $urandom;   // big jump, also wraps
    it.time_ms            = now_ms;
    it.voltage_fault_code = 2'($urandom);
    it.current_code       = 16'($urandom);
    it.temperature_code   = 16'($urandom);

    if (tmo_run < TIMEOUT_FAIL_LIMIT && $urandom_range(99) < 8) begin
      // timeout carries noise in the unused fields
      it.mode             = MODE_TIMEOUT;
      it.cell_link_error  = 1'($urandom);
      it.aux_link_error   = 1'($urandom);
      it.limit_link_error = 1'($urandom);
    end else begin
      it.mode             = MODE_REPORT;
      it.cell_link_error  = ($urandom_range(99) < 20);
      it.aux_link_error   = (aux_run < LINK_FAIL_LIMIT && $urandom_range(99) < 8);
      it.limit_link_error = (lim_run < LINK_FAIL_LIMIT && $urandom_range(99) < 8);
      if (volt_ep) it.voltage_fault_code = 2'($urandom_range(3, 1));
      else if ($urandom_range(99) < 95) it.voltage_fault_code = 2'd0;

      pick = $urandom_range(99);
      if (pick >= 10) begin
        if (!curr_ep)
          it.current_code = clamp16(zero_code + int'($urandom_range(400)) - 200);
        else if ($urandom_range(1))
          it.current_code = clamp16(zero_code + chg_lim + 1 + int'($urandom_range(3000)));
        else
          it.current_code = clamp16(zero_code + dis_lim - 1 - int'($urandom_range(3000)));
      end

      pick = $urandom_range(99);
      if (pick >= 10) begin
        if (!temp_ep) begin
          if (hot_lim <= cold_lim)
            it.temperature_code = 16'($urandom_range(cold_lim, hot_lim));
        end else if ($urandom_range(1) && hot_lim > 0) begin
          it.temperature_code = 16'($urandom_range(hot_lim - 1, 0));
        end else if (cold_lim < 65535) begin
          it.temperature_code = 16'($urandom_range(65535, cold_lim + 1));
        end else begin
          it.temperature_code = 16'($urandom_range(65534, 0));
        end
      end
    end
  endtask

  // one register write: setup cycle, then access cycle until pready
  task automatic write_reg(input logic [2:0] idx, input int value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
  endtask

  task automatic apply_settings(input setting_t s);
    int volt_hold, temp_hold, curr_hold;
    case (s)
      SET_TYPICAL: begin
        hot_lim   = $urandom_range(10000, 2000);
        cold_lim  = $urandom_range(30000, 15000);
        zero_code = $urandom_range(40000, 20000);
        chg_lim   = $urandom_range(20000, 1000);
        dis_lim   = -int'($urandom_range(30000, 1000));
        volt_hold = $urandom_range(600);
        temp_hold = $urandom_range(600);
        curr_hold = $urandom_range(600);
      end
      SET_MIN: begin
        hot_lim   = 0;
        cold_lim  = 0;
        zero_code = 0;
        chg_lim   = -65535;
        dis_lim   = -65535;
        volt_hold = 0;
        temp_hold = 0;
        curr_hold = 0;
      end
      SET_MAX: begin
        hot_lim   = 65535;
        cold_lim  = 65535;
        zero_code = 65535;
        chg_lim   = 65535;
        dis_lim   = 65535;
        volt_hold = 65535;
        temp_hold = 65535;
        curr_hold = 65535;
      end
      SET_RANDOM: begin
        hot_lim   = $urandom_range(65535);
        cold_lim  = $urandom_range(65535);
        zero_code = $urandom_range(65535);
        chg_lim   = int'($urandom_range(131070)) - 65535;
        dis_lim   = int'($urandom_range(131070)) - 65535;
        volt_hold = $urandom_range(65535);
        temp_hold = $urandom_range(65535);
        curr_hold = $urandom_range(65535);
      end
      default: begin
        hot_lim   = HOT_LIMIT_RST;
        cold_lim  = COLD_LIMIT_RST;
        zero_code = ZERO_CODE_RST;
        chg_lim   = CHARGE_LIM_RST;
        dis_lim   = DISCHG_LIM_RST;
        volt_hold = VOLT_HOLD_RST;
        temp_hold = TEMP_HOLD_RST;
        curr_hold = CURRENT_HOLD_RST;
      end
    endcase
    write_reg(REG_HOT_LIMIT, hot_lim);
    write_reg(REG_COLD_LIMIT, cold_lim);
    write_reg(REG_ZERO_CODE, zero_code);
    write_reg(REG_CHARGE_LIM, chg_lim);
    write_reg(REG_DISCHG_LIM, dis_lim);
    write_reg(REG_VOLT_HOLD, volt_hold);
    write_reg(REG_TEMP_HOLD, temp_hold);
    write_reg(REG_CURRENT_HOLD, curr_hold);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // stop sending and let every outstanding result come back
  task automatic drain();
    int waited;
    waited   = 0;
    in_valid <= 1'b0;
    while (due_count != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (3) @(posedge clk);
  endtask

  initial begin
    in_item_t    it;
    fail_route_t route;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_stall = 1'b0;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    idle_pct  = 22;
    stall_pct = 64;
    now_ms    = '0;
    volt_ep   = 1'b0;
    temp_ep   = 1'b0;
    curr_ep   = 1'b0;
    tmo_run   = 0;
    aux_run   = 0;
    lim_run   = 0;
    hot_lim   = HOT_LIMIT_RST;
    cold_lim  = COLD_LIMIT_RST;
    zero_code = ZERO_CODE_RST;
    chg_lim   = CHARGE_LIM_RST;
    dis_lim   = DISCHG_LIM_RST;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed part on the reset limits; slot index follows the report count
    send_report(32'd0, 0, 0, 0, 2'd0, 16'd30090, 16'd10000);  // healthy, relay released
    send_report(32'd1000, 0, 0, 0, 2'd3, 16'd30090, 16'd10000); // voltage fault starts
    send_report(32'd1500, 0, 0, 0, 2'd1, 16'd30090, 16'd10000); // elapsed equals hold
    send_report(32'd1501, 0, 0, 0, 2'd2, 16'd30090, 16'd10000); // one past hold: open
    send_report(32'd1600, 0, 0, 0, 2'd0, 16'd30090, 16'd10000); // cooldown starts
    send_report(32'd1700, 0, 0, 0, 2'd0, 16'd30090, 16'd10000); // cooldown exactly 100
    send_report(32'd1701, 0, 0, 0, 2'd0, 16'd30090, 16'd10000); // cooldown over
    // three timeouts in a row stay just below failure
    send_timeout(32'd1702);
    send_timeout(32'd1703);
    send_timeout(32'd1704);
    send_report(32'd2000, 0, 0, 0, 2'd0, 16'hFFFF, 16'd10000);  // charge overcurrent
    send_report(32'd2600, 0, 0, 0, 2'd0, 16'd0, 16'd10000);     // discharge side, timer out
    // every checksum error at once: all routines keep their state
    send_report(32'd2700, 1, 1, 1, 2'd3, 16'd0, 16'd0);
    // slots past the checked ones may be out of range without a fault
    send_report(32'd3000, 0, 0, 0, 2'd0, 16'd30090, 16'd0);
    send_report(32'd3001, 0, 0, 0, 2'd0, 16'd30090, 16'hFFFF);
    send_report(32'd3002, 0, 0, 0, 2'd0, 16'd30090, 16'd6499);
    send_report(32'd3003, 0, 0, 0, 2'd0, 16'd30090, 16'd23001);
    send_report(32'd3004, 0, 0, 0, 2'd0, 16'd30090, 16'd6500);
    send_report(32'd3005, 0, 0, 0, 2'd0, 16'd30090, 16'd23000);
    // slot 0 too hot, then temperature hold runs out
    send_report(32'd4000, 0, 0, 0, 2'd0, 16'd30090, 16'd0);
    send_report(32'd5001, 0, 0, 0, 2'd0, 16'd30090, 16'hFFFF);

    // random phases; idling swaps sides after two phases, then stops
    for (int ph = 0; ph < 6; ph++) begin
      case (ph / 2)
        0: begin
          idle_pct  = 22;
          stall_pct = 64;
        end
        1: begin
          idle_pct  = 64;
          stall_pct = 22;
        end
        default: begin
          idle_pct  = 0;
          stall_pct = 0;
        end
      endcase
      drain();
      apply_settings(PLAN[ph]);
      // odd phases start just short of the timestamp wrap
      if (ph % 2) now_ms = 32'hFFFF_FFFF - $urandom_range(5000);
      else now_ms = $urandom;
      repeat (ITEMS_PER_PHASE) begin
        make_item(it);
        send_item(it);
      end
    end

    // finally enter the sticky failure by one of its routes
    route = fail_route_t'($urandom_range(2));
    repeat (6) begin
      make_item(it);
      case (route)
        ROUTE_TIMEOUTS: it.mode = MODE_TIMEOUT;
        ROUTE_AUX_ERRORS: begin
          it.mode           = MODE_REPORT;
          it.aux_link_error = 1'b1;
        end
        default: begin
          it.mode             = MODE_REPORT;
          it.limit_link_error = 1'b1;
        end
      endcase
      send_item(it);
    end
    // noise once failed: everything is ignored, relay stays open
    repeat (8) begin
      it.mode               = 1'($urandom);
      it.time_ms            = $urandom;
      it.cell_link_error    = 1'($urandom);
      it.aux_link_error     = 1'($urandom);
      it.limit_link_error   = 1'($urandom);
      it.voltage_fault_code = 2'($urandom);
      it.current_code       = 16'($urandom);
      it.temperature_code   = 16'($urandom);
      send_item(it);
    end

    drain();
    if (mismatches == 0 && due_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
